[rtl/kmi_pkg.sv]
// Shared types, constants and register indexes of the keep-out motion interlock.
package kmi_pkg;

    // Heading resolution used for the trigonometry and output scaling of cos and sin.
    localparam int ANGLE_TABLE_BITS = 10;
    localparam int TRIG_FRAC_BITS   = 15;

    localparam int COORD_W   = 14;
    localparam int HEADING_W = 16;
    localparam int DIR_W     = 4;
    localparam int SPEED_W   = 17;
    localparam int TURN_W    = 23;
    localparam int TURN_MAG_W = TURN_W - 1;
    localparam int TRIG_W    = 16;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 32;
    localparam int DOT_W     = 35;
    localparam int NUM_ZONES = 3;

    // Quarter-wave sine polynomial coefficients, Q15 arithmetic.
    localparam logic [15:0] POLY_A = 16'd51472;
    localparam logic [14:0] POLY_B = 15'd21024;
    localparam logic [11:0] POLY_C = 12'd2320;
    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [14:0] SINE_MAX = 15'h7FFF;
    localparam logic [ANGLE_TABLE_BITS-1:0] PHASE_QUARTER =
        ANGLE_TABLE_BITS'(1) << (ANGLE_TABLE_BITS - 2);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEPOUT_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_UNIT      = 3'd5;

    // Direction command codes.
    localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
    localparam logic [DIR_W-1:0] DIR_UP         = 4'd1;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd4;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd5;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd7;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd8;

    localparam logic [TURN_MAG_W-1:0] TURN_SLOW = 22'd6;
    localparam logic [TURN_MAG_W-1:0] TURN_FAST = 22'd40;

    // Queue between classification and command mapping.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [12:0] field_width;
        logic [12:0] field_height;
        logic [9:0]  edge_margin;
        logic [9:0]  keepout_radius;
        logic [15:0] speed_limit;
        logic [15:0] turn_unit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        field_width:    13'd1800,
        field_height:   13'd2700,
        edge_margin:    10'd130,
        keepout_radius: 10'd255,
        speed_limit:    16'd100,
        turn_unit:      16'd1
    };

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic             fwd_ok;
        logic             bwd_ok;
        logic [DIR_W-1:0] dir;
    } t_cls;

    // Edge band hits of one pose.
    typedef struct packed {
        logic lo_y;
        logic hi_x;
        logic hi_y;
        logic lo_x;
    } t_edge;

endpackage

[rtl/keepout_motion_interlock.sv]
// Top level of the keep-out motion interlock with its configuration registers.
// Takes one pose and direction command per cycle while o_stall is low and
// returns one motion command per item, in order. Each item passes through six
// front stages (input register, the four multiplier stages of the sine and
// cosine polynomial units, and a dot product stage), the four-entry queue and
// the output register. The sustained rate is one item per clock while neither
// stall holds the flow, set by the fully pipelined sine and cosine units and
// the per-zone distance multipliers. The front stalls only when the queue is
// full, and the queue absorbs items while a result waits to be taken.
// Configuration writes are always accepted and should be issued while no item
// is in flight.
module keepout_motion_interlock (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [kmi_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [kmi_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [kmi_pkg::HEADING_W-1:0]        i_heading,
    input  logic [kmi_pkg::DIR_W-1:0]            i_direction,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [kmi_pkg::SPEED_W-1:0]   o_speed,
    output logic signed [kmi_pkg::TURN_W-1:0]    o_turn_rate_tenths,
    output logic                                 o_brake,
    output logic                                 o_forward_allowed,
    output logic                                 o_backward_allowed,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kmi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [kmi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import kmi_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic c_push, c_pop, c_full, c_empty;
    t_cls c_front_cls, c_back_cls;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIELD_WIDTH:    n_cfg.field_width    = i_cfg_data[12:0];
                REG_FIELD_HEIGHT:   n_cfg.field_height   = i_cfg_data[12:0];
                REG_EDGE_MARGIN:    n_cfg.edge_margin    = i_cfg_data[9:0];
                REG_KEEPOUT_RADIUS: n_cfg.keepout_radius = i_cfg_data[9:0];
                REG_SPEED_LIMIT:    n_cfg.speed_limit    = i_cfg_data;
                REG_TURN_UNIT:      n_cfg.turn_unit      = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    kmi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_heading   (i_heading),
        .i_direction (i_direction),
        .i_q_full    (c_full),
        .o_push      (c_push),
        .o_cls       (c_front_cls)
    );

    kmi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_data  (c_front_cls),
        .o_full  (c_full),
        .i_pop   (c_pop),
        .o_data  (c_back_cls),
        .o_empty (c_empty)
    );

    kmi_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (c_empty),
        .i_q_data           (c_back_cls),
        .o_pop              (c_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_speed            (o_speed),
        .o_turn_rate_tenths (o_turn_rate_tenths),
        .o_brake            (o_brake),
        .o_forward_allowed  (o_forward_allowed),
        .o_backward_allowed (o_backward_allowed)
    );

endmodule

[rtl/kmi_sine.sv]
// Four-stage pipelined Q1.15 sine of a quantized heading phase.
module kmi_sine (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [kmi_pkg::ANGLE_TABLE_BITS-1:0]   i_phase,
    output logic signed [kmi_pkg::TRIG_W-1:0]      o_value
);
    import kmi_pkg::*;

    logic [1:0]  c_quad;
    logic [13:0] c_rem;
    logic [14:0] c_arg;
    logic [15:0] c_t;
    logic [31:0] c_sq;
    logic [31:0] c_p2;
    logic [14:0] c_mid;
    logic [31:0] c_p3;
    logic [15:0] c_out;
    logic [31:0] c_p4;
    logic [16:0] c_s;
    logic [14:0] c_sat;
    logic [14:0] c_shift;
    logic signed [TRIG_W-1:0] n_value;

    logic [15:0] r1_t, r1_t2;
    logic        r1_neg;
    logic [15:0] r2_t, r2_t2;
    logic [14:0] r2_mid;
    logic        r2_neg;
    logic [15:0] r3_t, r3_out;
    logic        r3_neg;
    logic signed [TRIG_W-1:0] r4_value;

    always_comb begin
        c_quad  = i_phase[ANGLE_TABLE_BITS-1 -: 2];
        c_rem   = 14'(i_phase[ANGLE_TABLE_BITS-3:0]) << (16 - ANGLE_TABLE_BITS);
        // Odd quadrants mirror the quarter wave.
        c_arg   = c_quad[0] ? (QUARTER_TURN - {1'b0, c_rem}) : {1'b0, c_rem};
        c_t     = {c_arg, 1'b0};
        c_sq    = c_t * c_t;

        c_p2    = POLY_C * r1_t2;
        c_mid   = POLY_B - 15'(c_p2[27:15]);

        c_p3    = r2_mid * r2_t2;
        c_out   = POLY_A - c_p3[30:15];

        c_p4    = r3_out * r3_t;
        c_s     = c_p4[31:15];
        c_sat   = (c_s > 17'(SINE_MAX)) ? SINE_MAX : c_s[14:0];
        c_shift = c_sat >> (15 - TRIG_FRAC_BITS);
        n_value = r3_neg ? -$signed({1'b0, c_shift}) : $signed({1'b0, c_shift});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t     <= c_t;
            r1_t2    <= c_sq[30:15];
            r1_neg   <= c_quad[1];
            r2_t     <= r1_t;
            r2_t2    <= r1_t2;
            r2_mid   <= c_mid;
            r2_neg   <= r1_neg;
            r3_t     <= r2_t;
            r3_out   <= c_out;
            r3_neg   <= r2_neg;
            r4_value <= n_value;
        end
    end

    assign o_value = r4_value;

endmodule

[rtl/kmi_front.sv]
// Front pipeline: takes poses and classifies forward and backward permission.
module kmi_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kmi_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [kmi_pkg::COORD_W-1:0]    i_pos_x,
    input  logic signed [kmi_pkg::COORD_W-1:0]    i_pos_y,
    input  logic [kmi_pkg::HEADING_W-1:0]         i_heading,
    input  logic [kmi_pkg::DIR_W-1:0]             i_direction,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output kmi_pkg::t_cls                         o_cls
);
    import kmi_pkg::*;

    localparam int LAST = 5;

    logic c_en;

    logic [LAST:0] r_vld;

    logic signed [COORD_W-1:0]        r0_x, r0_y;
    logic [ANGLE_TABLE_BITS-1:0]      r0_phase;
    logic [ANGLE_TABLE_BITS-1:0]      c_cos_phase;
    logic [DIR_W-1:0]                 r0_dir;

    logic [DIR_W-1:0]                 r1_dir, r2_dir, r3_dir, r4_dir, r5_dir;
    t_edge                            c_edge, r1_edge, r2_edge, r3_edge, r4_edge;
    logic signed [DIST_W-1:0]         c_dx [NUM_ZONES];
    logic signed [DIST_W-1:0]         c_dy [NUM_ZONES];
    logic signed [DIST_W-1:0]         r1_dx [NUM_ZONES], r1_dy [NUM_ZONES];
    logic signed [DIST_W-1:0]         r2_dx [NUM_ZONES], r2_dy [NUM_ZONES];
    logic signed [DIST_W-1:0]         r3_dx [NUM_ZONES], r3_dy [NUM_ZONES];
    logic signed [DIST_W-1:0]         r4_dx [NUM_ZONES], r4_dy [NUM_ZONES];
    logic signed [2*DIST_W-1:0]       c_sqx [NUM_ZONES], c_sqy [NUM_ZONES];
    logic [SQ_W-1:0]                  r2_sqx [NUM_ZONES], r2_sqy [NUM_ZONES];
    logic [NUM_ZONES-1:0]             c_inside, r3_inside, r4_inside, r5_inside;
    logic [23:0]                      r_r2;
    logic [19:0]                      c_rad_sq;
    logic signed [TRIG_W-1:0]         c_vy, c_vx;
    logic                             c_eblk_f, c_eblk_b, r5_eblk_f, r5_eblk_b;
    logic signed [TRIG_W+DIST_W-1:0]  c_px [NUM_ZONES], c_py [NUM_ZONES];
    logic signed [TRIG_W+DIST_W-1:0]  r5_px [NUM_ZONES], r5_py [NUM_ZONES];
    logic signed [DOT_W-1:0]          c_dot;
    logic                             c_zblk_f, c_zblk_b;

    logic signed [COORD_W:0]          c_xs, c_ys, c_ms, c_wm, c_hm;
    logic [14:0]                      c_kw, c_kh;

    // The pipeline moves unless a finished item has no room in the queue.
    assign c_en    = !(r_vld[LAST] && i_q_full);
    assign o_stall = !c_en;
    assign o_push  = r_vld[LAST] && !i_q_full;

    assign c_cos_phase = r0_phase + PHASE_QUARTER;

    kmi_sine u_sin (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_phase (r0_phase),
        .o_value (c_vy)
    );

    kmi_sine u_cos (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_phase (c_cos_phase),
        .o_value (c_vx)
    );

    // Stage 1: edge band tests and offsets to the three zone centers at 4x scale.
    always_comb begin
        c_xs = {r0_x[COORD_W-1], r0_x};
        c_ys = {r0_y[COORD_W-1], r0_y};
        c_ms = $signed({5'b0, i_cfg.edge_margin});
        c_wm = $signed({2'b0, i_cfg.field_width}) - c_ms;
        c_hm = $signed({2'b0, i_cfg.field_height}) - c_ms;
        c_edge.lo_y = c_ys < c_ms;
        c_edge.hi_x = c_xs > c_wm;
        c_edge.hi_y = c_ys > c_hm;
        c_edge.lo_x = c_xs < c_ms;
        c_kw = '0;
        c_kh = '0;
        for (int k = 0; k < NUM_ZONES; k++) begin
            c_kw = 15'(i_cfg.field_width) * 15'(k + 1);
            c_kh = 15'(i_cfg.field_height) * 15'(k + 1);
            c_dx[k] = $signed({3'b000, c_kw})
                    - ($signed({{(DIST_W-COORD_W){r0_x[COORD_W-1]}}, r0_x}) <<< 2);
            c_dy[k] = $signed({3'b000, c_kh})
                    - ($signed({{(DIST_W-COORD_W){r0_y[COORD_W-1]}}, r0_y}) <<< 2);
        end
    end

    // Stages 2 and 3: squared distances, then compare against the squared radius.
    always_comb begin
        c_rad_sq = i_cfg.keepout_radius * i_cfg.keepout_radius;
        for (int k = 0; k < NUM_ZONES; k++) begin
            c_sqx[k] = r1_dx[k] * r1_dx[k];
            c_sqy[k] = r1_dy[k] * r1_dy[k];
            c_inside[k] = ({1'b0, r2_sqx[k]} + {1'b0, r2_sqy[k]}) < 33'(r_r2);
        end
    end

    // Stage 5: heading-dependent choice of the forbidden direction.
    always_comb begin
        c_eblk_f = (r4_edge.lo_y && (c_vy < 0)) || (r4_edge.hi_x && (c_vx > 0))
                || (r4_edge.hi_y && (c_vy > 0)) || (r4_edge.lo_x && (c_vx < 0));
        c_eblk_b = (r4_edge.lo_y && !(c_vy < 0)) || (r4_edge.hi_x && !(c_vx > 0))
                || (r4_edge.hi_y && !(c_vy > 0)) || (r4_edge.lo_x && !(c_vx < 0));
        for (int k = 0; k < NUM_ZONES; k++) begin
            c_px[k] = c_vx * r4_dx[k];
            c_py[k] = c_vy * r4_dy[k];
        end
    end

    // Zone decision on the registered products, summed to dot products as the item leaves.
    always_comb begin
        c_zblk_f = 1'b0;
        c_zblk_b = 1'b0;
        c_dot    = '0;
        for (int k = 0; k < NUM_ZONES; k++) begin
            c_dot = DOT_W'(r5_px[k]) + DOT_W'(r5_py[k]);
            if (r5_inside[k]) begin
                if (c_dot > 0) begin
                    c_zblk_f = 1'b1;
                end else begin
                    c_zblk_b = 1'b1;
                end
            end
        end
        o_cls.fwd_ok = !(r5_eblk_f || c_zblk_f);
        o_cls.bwd_ok = !(r5_eblk_b || c_zblk_b);
        o_cls.dir    = r5_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (c_en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= {c_rad_sq, 4'b0000};
        if (c_en) begin
            r0_x      <= i_pos_x;
            r0_y      <= i_pos_y;
            r0_phase  <= i_heading[HEADING_W-1 -: ANGLE_TABLE_BITS];
            r0_dir    <= i_direction;
            r1_dir    <= r0_dir;
            r2_dir    <= r1_dir;
            r3_dir    <= r2_dir;
            r4_dir    <= r3_dir;
            r5_dir    <= r4_dir;
            r1_edge   <= c_edge;
            r2_edge   <= r1_edge;
            r3_edge   <= r2_edge;
            r4_edge   <= r3_edge;
            r3_inside <= c_inside;
            r4_inside <= r3_inside;
            r5_inside <= r4_inside;
            r5_eblk_f <= c_eblk_f;
            r5_eblk_b <= c_eblk_b;
            for (int k = 0; k < NUM_ZONES; k++) begin
                r1_dx[k]  <= c_dx[k];
                r1_dy[k]  <= c_dy[k];
                r2_dx[k]  <= r1_dx[k];
                r2_dy[k]  <= r1_dy[k];
                r3_dx[k]  <= r2_dx[k];
                r3_dy[k]  <= r2_dy[k];
                r4_dx[k]  <= r3_dx[k];
                r4_dy[k]  <= r3_dy[k];
                r2_sqx[k] <= c_sqx[k][SQ_W-1:0];
                r2_sqy[k] <= c_sqy[k][SQ_W-1:0];
                r5_px[k]  <= c_px[k];
                r5_py[k]  <= c_py[k];
            end
        end
    end

endmodule

[rtl/kmi_queue.sv]
// Small FIFO of classified items between the front and the back.
module kmi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmi_pkg::t_cls  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output kmi_pkg::t_cls  o_data,
    output logic           o_empty
);
    import kmi_pkg::*;

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/kmi_back.sv]
// Back end: maps a classified direction command to speed, turn rate and brake.
module kmi_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kmi_pkg::t_cfg                        i_cfg,
    input  logic                                 i_q_empty,
    input  kmi_pkg::t_cls                        i_q_data,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [kmi_pkg::SPEED_W-1:0]   o_speed,
    output logic signed [kmi_pkg::TURN_W-1:0]    o_turn_rate_tenths,
    output logic                                 o_brake,
    output logic                                 o_forward_allowed,
    output logic                                 o_backward_allowed
);
    import kmi_pkg::*;

    logic                       c_lin_f, c_lin_b, c_turn_neg;
    logic [TURN_MAG_W-1:0]      c_turn_mag, c_slow, c_fast;
    logic signed [SPEED_W-1:0]  n_speed, c_v;
    logic signed [TURN_W-1:0]   n_turn;
    logic                       n_brake;

    logic                       r_valid;
    logic signed [SPEED_W-1:0]  r_speed;
    logic signed [TURN_W-1:0]   r_turn;
    logic                       r_brake, r_fwd, r_bwd;

    // The output register reloads from a non-empty queue whenever it is empty or being taken.
    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    always_comb begin
        c_lin_f    = 1'b0;
        c_lin_b    = 1'b0;
        c_turn_neg = 1'b0;
        c_turn_mag = '0;
        c_slow     = TURN_MAG_W'(i_cfg.turn_unit) * TURN_SLOW;
        c_fast     = TURN_MAG_W'(i_cfg.turn_unit) * TURN_FAST;
        case (i_q_data.dir)
            DIR_UP: begin
                c_lin_f = 1'b1;
            end
            DIR_UP_RIGHT: begin
                c_lin_f    = 1'b1;
                c_turn_mag = c_slow;
                c_turn_neg = 1'b1;
            end
            DIR_RIGHT: begin
                c_turn_mag = c_fast;
                c_turn_neg = 1'b1;
            end
            DIR_DOWN_RIGHT: begin
                c_lin_b    = 1'b1;
                c_turn_mag = c_slow;
            end
            DIR_DOWN: begin
                c_lin_b = 1'b1;
            end
            DIR_DOWN_LEFT: begin
                c_lin_b    = 1'b1;
                c_turn_mag = c_slow;
                c_turn_neg = 1'b1;
            end
            DIR_LEFT: begin
                c_turn_mag = c_fast;
            end
            DIR_UP_LEFT: begin
                c_lin_f    = 1'b1;
                c_turn_mag = c_slow;
            end
            default: begin
            end
        endcase

        c_v     = $signed({1'b0, i_cfg.speed_limit});
        n_speed = '0;
        if (c_lin_f && i_q_data.fwd_ok) begin
            n_speed = c_v;
        end else if (c_lin_b && i_q_data.bwd_ok) begin
            n_speed = -c_v;
        end
        n_brake = (c_lin_f && !i_q_data.fwd_ok) || (c_lin_b && !i_q_data.bwd_ok);
        n_turn  = c_turn_neg ? -$signed({1'b0, c_turn_mag}) : $signed({1'b0, c_turn_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_speed <= n_speed;
            r_turn  <= n_turn;
            r_brake <= n_brake;
            r_fwd   <= i_q_data.fwd_ok;
            r_bwd   <= i_q_data.bwd_ok;
        end
    end

    assign o_valid            = r_valid;
    assign o_speed            = r_speed;
    assign o_turn_rate_tenths = r_turn;
    assign o_brake            = r_brake;
    assign o_forward_allowed  = r_fwd;
    assign o_backward_allowed = r_bwd;

endmodule
